// File: rtl/core/bid_pkg.sv
package bid_pkg;

	localparam int Depth = 16;
	localparam int IdxW = $clog2(Depth);

	localparam logic [1:0] CMD_PUSH_TAIL = 2'd0;
	localparam logic [1:0] CMD_PUSH_HEAD = 2'd1;
	localparam logic [1:0] CMD_POP_HEAD = 2'd2;
	localparam logic [1:0] CMD_POP_TAIL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] ident_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] ident_out;
		logic [7:0] slot;
		logic [1:0] status;
		logic [7:0] fill;
	} rsp_t;

endpackage

// File: rtl/core/bounded_id_deque_core.sv
// channel  dir  handshake              payload
// cmd      in   cmd_valid / cmd_stall  bid_pkg::cmd_t (command, ident_in)
// rsp      out  rsp_valid / rsp_stall  bid_pkg::rsp_t (ident_out, slot, status, fill)
//
// a command is registered on transfer, executed against the entry shift register
// and its response registered; one command per cycle sustained while the response is
// not stalled, the response register following the input register.
// arst_n clears the queue, the count and both valid flags.
// rsp_stall holds the response register and, through it, the input register;
// cmd_stall rises only while a command waits behind a stalled response.
module bounded_id_deque_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  bid_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bid_pkg::rsp_t  rsp
);

	logic                      cmd_valid_s1;
	bid_pkg::cmd_t             cmd_s1;
	logic [31:0]               entries_q [bid_pkg::Depth];
	logic [bid_pkg::IdxW-1:0]  held_q;
	logic                      rsp_valid_q;
	bid_pkg::rsp_t             rsp_q;

	logic                      advance;
	logic                      exec;
	logic [31:0]               entries_d [bid_pkg::Depth];
	logic [bid_pkg::IdxW-1:0]  held_d;
	bid_pkg::rsp_t             rsp_d;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign exec = cmd_valid_s1 && advance;
	assign cmd_stall = cmd_valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		logic is_full;
		logic is_empty;
		logic [bid_pkg::IdxW-1:0] last;
		is_full = (held_q == bid_pkg::IdxW'(bid_pkg::Depth - 1));
		is_empty = (held_q == '0);
		last = held_q - bid_pkg::IdxW'(1);
		for (int i = 0; i < bid_pkg::Depth; i++) begin
			entries_d[i] = entries_q[i];
		end
		held_d = held_q;
		rsp_d.ident_out = '0;
		rsp_d.slot = '0;
		rsp_d.status = bid_pkg::ST_OK;
		unique case (cmd_s1.command)
			bid_pkg::CMD_PUSH_TAIL: begin
				if (is_full) begin
					rsp_d.status = bid_pkg::ST_FULL;
				end else begin
					entries_d[held_q] = cmd_s1.ident_in;
					rsp_d.slot = 8'(held_q);
					held_d = held_q + bid_pkg::IdxW'(1);
				end
			end
			bid_pkg::CMD_PUSH_HEAD: begin
				if (is_full) begin
					rsp_d.status = bid_pkg::ST_FULL;
				end else begin
					// shift up through the current tail
					for (int i = 1; i < bid_pkg::Depth; i++) begin
						if (bid_pkg::IdxW'(i) <= held_q) begin
							entries_d[i] = entries_q[i-1];
						end
					end
					entries_d[0] = cmd_s1.ident_in;
					held_d = held_q + bid_pkg::IdxW'(1);
				end
			end
			bid_pkg::CMD_POP_HEAD: begin
				if (is_empty) begin
					rsp_d.status = bid_pkg::ST_EMPTY;
				end else begin
					rsp_d.ident_out = entries_q[0];
					for (int i = 0; i < bid_pkg::Depth - 1; i++) begin
						entries_d[i] = entries_q[i+1];
					end
					entries_d[bid_pkg::Depth-1] = '0;
					held_d = last;
				end
			end
			bid_pkg::CMD_POP_TAIL: begin
				if (is_empty) begin
					rsp_d.status = bid_pkg::ST_EMPTY;
				end else begin
					rsp_d.ident_out = entries_q[last];
					entries_d[last] = '0;
					held_d = last;
				end
			end
			default: begin
				rsp_d.status = bid_pkg::ST_OK;
			end
		endcase
		rsp_d.fill = 8'(held_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < bid_pkg::Depth; i++) begin
				entries_q[i] <= '0;
			end
		end else if (exec) begin
			held_q <= held_d;
			for (int i = 0; i < bid_pkg::Depth; i++) begin
				entries_q[i] <= entries_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= cmd_valid_s1;
		end
	end

	// response payload moves only with a transfer slot
	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
